// ===== rtl/core/wrm_pkg.sv =====
// Shared constants and types for the windowed RMS / min / max block.
`default_nettype none

package wrm_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COUNT_BITS_DEF  = 12;
	localparam int WINDOW_RESET    = 500;
	localparam int JOB_DEPTH       = 2;

	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;

	localparam logic REG_WINDOW_LEN = 1'b0;

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_DIV  = 4'b0010,
		B_SQRT = 4'b0100,
		B_HOLD = 4'b1000
	} back_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/wrm_front.sv =====
// Front end: takes samples, squares them and keeps the window statistics.
`default_nettype none

module wrm_front #(
	parameter int SB = 16,
	parameter int CB = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [CB-1:0] window_len,
	input  logic [SB-1:0] sample,
	input  logic          push,
	output logic          full,
	output logic          job_push,
	input  logic          job_full,
	output logic [2*SB+CB+CB+2*SB-1:0] job_data
);

	localparam int SQ_W = 2 * SB;
	localparam int SW   = 2 * SB + CB;

	logic            busy_q;
	logic [SB-1:0]   sample_q;
	logic [SQ_W-1:0] sq_q;
	logic [CB-1:0]   count_q;
	logic [SB-1:0]   min_q;
	logic [SB-1:0]   max_q;
	logic [SW-1:0]   sum_q;

	logic            first;
	logic [CB-1:0]   n_d;
	logic [SB-1:0]   min_d;
	logic [SB-1:0]   max_d;
	logic [SW-1:0]   sum_d;
	logic            win_done;
	logic            advance;

	assign full     = busy_q;
	assign job_push = busy_q;
	assign advance  = busy_q && !job_full;

	always_comb begin
		first    = (count_q == '0);
		n_d      = count_q + CB'(1);
		win_done = (n_d >= window_len);
		min_d    = min_q;
		max_d    = max_q;
		if (first) begin
			min_d = sample_q;
			max_d = sample_q;
			sum_d = SW'(sq_q);
		end else begin
			if (sample_q < min_q) begin
				min_d = sample_q;
			end else if (sample_q > max_q) begin
				max_d = sample_q;
			end
			sum_d = sum_q + SW'(sq_q);
		end
	end

	assign job_data = {sum_d, n_d, min_d, max_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			count_q <= '0;
			min_q   <= '0;
			max_q   <= '0;
			sum_q   <= '0;
		end else begin
			if (push && !busy_q) begin
				busy_q <= 1'b1;
			end else if (advance) begin
				busy_q  <= 1'b0;
				min_q   <= min_d;
				max_q   <= max_d;
				sum_q   <= sum_d;
				count_q <= win_done ? '0 : n_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !busy_q) begin
			sample_q <= sample;
			sq_q     <= SQ_W'(sample) * SQ_W'(sample);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/wrm_jobq.sv =====
// Short queue of statistics words between the front and back ends.
`default_nettype none

module wrm_jobq #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign valid    = (cnt_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/wrm_back.sv =====
// Back end: bit-serial mean divide, bit-serial square root, result register.
`default_nettype none

module wrm_back #(
	parameter int SB = 16,
	parameter int CB = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  logic [2*SB+CB+CB+2*SB-1:0] job_data,
	output logic          job_pop,
	output logic [SB-1:0] rms_value,
	output logic [SB-1:0] min_value,
	output logic [SB-1:0] max_value,
	output logic [CB-1:0] samples_seen,
	output logic          empty,
	input  logic          pop
);

	import wrm_pkg::*;

	localparam int SW    = 2 * SB + CB;
	localparam int RW    = 2 * SB;
	localparam int CNT_W = $clog2(SW);

	back_state_t     state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SW-1:0]   dq_q;
	logic [CB-1:0]   drem_q;
	logic [CB-1:0]   n_q;
	logic [SB-1:0]   min_q;
	logic [SB-1:0]   max_q;
	logic [RW-1:0]   rad_q;
	logic [SB+1:0]   srem_q;
	logic [SB-1:0]   root_q;
	logic            out_valid_q;

	logic [CB:0]     d_shift;
	logic [CB:0]     d_diff;
	logic            d_ge;
	logic [SW-1:0]   d_quot;
	logic [SB+1:0]   s_shift;
	logic [SB+1:0]   s_trial;
	logic            s_ge;
	logic            load_out;

	assign job_pop  = (state_q == B_IDLE) && job_valid;
	assign load_out = (state_q == B_HOLD) && (!out_valid_q || pop);
	assign empty    = !out_valid_q;

	always_comb begin
		d_shift = {drem_q, dq_q[SW-1]};
		d_ge    = (d_shift >= {1'b0, n_q});
		d_diff  = d_shift - {1'b0, n_q};
		d_quot  = {dq_q[SW-2:0], d_ge};
		s_shift = {srem_q[SB-1:0], rad_q[RW-1:RW-2]};
		s_trial = {root_q, 2'b01};
		s_ge    = (s_shift >= s_trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					if (cnt_q == '0) begin
						state_q <= B_SQRT;
					end
				end
				B_SQRT: begin
					if (cnt_q == '0) begin
						state_q <= B_HOLD;
					end
				end
				B_HOLD: begin
					if (load_out) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					{dq_q, n_q, min_q, max_q} <= job_data;
					drem_q <= '0;
					cnt_q  <= CNT_W'(SW - 1);
				end
			end
			B_DIV: begin
				drem_q <= d_ge ? d_diff[CB-1:0] : d_shift[CB-1:0];
				dq_q   <= d_quot;
				if (cnt_q == '0) begin
					rad_q  <= d_quot[RW-1:0];
					srem_q <= '0;
					root_q <= '0;
					cnt_q  <= CNT_W'(SB - 1);
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
			B_SQRT: begin
				srem_q <= s_ge ? s_shift - s_trial : s_shift;
				root_q <= {root_q[SB-2:0], s_ge};
				rad_q  <= {rad_q[RW-3:0], 2'b00};
				cnt_q  <= cnt_q - CNT_W'(1);
			end
			B_HOLD: begin
				if (load_out) begin
					rms_value    <= root_q;
					min_value    <= min_q;
					max_value    <= max_q;
					samples_seen <= n_q;
				end
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/window_rms_min_max.sv =====
// Windowed RMS / min / max of 8.8 samples: top level with APB register.
// Path from push to result: sample register, job queue, then the one-bit-per-cycle divide
// and square root in the back end, then the result register.
// The back end takes a new word from the queue only once its last result is loaded.
// The front end takes no new sample until the last one is passed to the two-word queue.
// Reset: arst_n clears window state to zero and window_len to 500.
`default_nettype none

module window_rms_min_max #(
	parameter int SAMPLE_BITS = wrm_pkg::SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = wrm_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [wrm_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [wrm_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [wrm_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                              pready,
	input  logic [SAMPLE_BITS-1:0]            sample,
	input  logic                              push,
	output logic                              full,
	output logic [SAMPLE_BITS-1:0]            rms_value,
	output logic [SAMPLE_BITS-1:0]            min_value,
	output logic [SAMPLE_BITS-1:0]            max_value,
	output logic [COUNT_BITS-1:0]             samples_seen,
	output logic                              empty,
	input  logic                              pop
);

	import wrm_pkg::*;

	localparam int JOB_W = 2 * SAMPLE_BITS + COUNT_BITS + COUNT_BITS + 2 * SAMPLE_BITS;

	logic [COUNT_BITS-1:0] window_len_q;
	logic                  reg_hit;
	logic                  job_push;
	logic                  job_full;
	logic                  job_valid;
	logic                  job_pop;
	logic [JOB_W-1:0]      job_in;
	logic [JOB_W-1:0]      job_out;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_WINDOW_LEN);
	assign prdata  = reg_hit ? APB_DATA_BITS'(window_len_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= COUNT_BITS'(WINDOW_RESET);
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			window_len_q <= pwdata[COUNT_BITS-1:0];
		end
	end

	wrm_front #(
		.SB(SAMPLE_BITS),
		.CB(COUNT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.window_len(window_len_q),
		.sample    (sample),
		.push      (push),
		.full      (full),
		.job_push  (job_push),
		.job_full  (job_full),
		.job_data  (job_in)
	);

	wrm_jobq #(
		.WIDTH(JOB_W),
		.DEPTH(JOB_DEPTH)
	) u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_data(job_in),
		.full     (job_full),
		.pop      (job_pop),
		.valid    (job_valid),
		.pop_data (job_out)
	);

	wrm_back #(
		.SB(SAMPLE_BITS),
		.CB(COUNT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (job_valid),
		.job_data    (job_out),
		.job_pop     (job_pop),
		.rms_value   (rms_value),
		.min_value   (min_value),
		.max_value   (max_value),
		.samples_seen(samples_seen),
		.empty       (empty),
		.pop         (pop)
	);

	a_front_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(full && job_full) |=> full)
		else $error("front dropped a word while queue full");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (samples_seen != '0))
		else $error("result with zero sample count");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (min_value <= max_value))
		else $error("minimum above maximum");

	a_rms_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((rms_value >= min_value) && (rms_value <= max_value)))
		else $error("rms outside min/max range");

endmodule

`default_nettype wire

// ===== test/window_rms_min_max_checker.sv =====
// Checker for window_rms_min_max: tracks window_len writes, predicts each result word, compares.
`timescale 1ns / 1ps

module window_rms_min_max_checker
	import wrm_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_ADDR_BITS-1:0]  paddr,
	input  logic [APB_DATA_BITS-1:0]  pwdata,
	input  logic [APB_DATA_BITS-1:0]  prdata,
	input  logic                      pready,
	input  logic [SAMPLE_BITS-1:0]    sample,
	input  logic                      push,
	input  logic                      full,
	input  logic [SAMPLE_BITS-1:0]    rms_value,
	input  logic [SAMPLE_BITS-1:0]    min_value,
	input  logic [SAMPLE_BITS-1:0]    max_value,
	input  logic [COUNT_BITS-1:0]     samples_seen,
	input  logic                      empty,
	input  logic                      pop,
	output int                        fail_count,
	output int                        words_pending
);

	localparam int SUM_BITS = 2 * SAMPLE_BITS + COUNT_BITS;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] rms;
		logic [SAMPLE_BITS-1:0] lo;
		logic [SAMPLE_BITS-1:0] hi;
		logic [COUNT_BITS-1:0]  n;
	} stats_t;

	stats_t stats_due[$];

	logic [COUNT_BITS-1:0]  win_len;
	logic [COUNT_BITS-1:0]  win_count;
	logic [SUM_BITS-1:0]    sq_sum;
	logic [SAMPLE_BITS-1:0] run_lo;
	logic [SAMPLE_BITS-1:0] run_hi;

	// floor of the square root, built one result bit at a time from the top
	function automatic logic [SAMPLE_BITS-1:0] root_floor(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int b = SAMPLE_BITS - 1; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r[SAMPLE_BITS-1:0];
	endfunction

	function automatic stats_t fold_sample(input logic [SAMPLE_BITS-1:0] s);
		stats_t      r;
		logic [63:0] sq;
		logic [63:0] n;
		logic [63:0] mean;
		sq = 64'(s) * 64'(s);
		if (win_count == '0) begin
			run_lo = s;
			run_hi = s;
			sq_sum = SUM_BITS'(sq);
		end else begin
			if (s < run_lo)
				run_lo = s;
			else if (s > run_hi)
				run_hi = s;
			sq_sum = sq_sum + SUM_BITS'(sq);
		end
		n = 64'(win_count) + 64'd1;
		mean = 64'(sq_sum) / n;
		r.rms = root_floor(mean);
		r.lo = run_lo;
		r.hi = run_hi;
		r.n = COUNT_BITS'(n);
		// window closes at or past window_len; a length of zero acts like one
		if (n >= 64'(win_len))
			win_count = '0;
		else
			win_count = COUNT_BITS'(n);
		return r;
	endfunction

	function automatic void check_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stats_t want;
		if (!arst_n) begin
			win_len = COUNT_BITS'(WINDOW_RESET);
			win_count = '0;
			sq_sum = '0;
			run_lo = '0;
			run_hi = '0;
			stats_due.delete();
			fail_count = 0;
			words_pending = 0;
		end else begin
			if (pop && !empty) begin
				if (stats_due.size() == 0) begin
					$error("result word with none expected: rms_value %0d", rms_value);
					fail_count++;
				end else begin
					want = stats_due.pop_front();
					check_field("rms_value", 32'(want.rms), 32'(rms_value));
					check_field("min_value", 32'(want.lo), 32'(min_value));
					check_field("max_value", 32'(want.hi), 32'(max_value));
					check_field("samples_seen", 32'(want.n), 32'(samples_seen));
				end
			end
			if (psel && penable && pready && (paddr >> 2) == REG_WINDOW_LEN) begin
				if (pwrite)
					win_len = pwdata[COUNT_BITS-1:0];
				else
					check_field("prdata", 32'(win_len), 32'(prdata));
			end
			if (push && !full)
				stats_due.push_back(fold_sample(sample));
			words_pending = stats_due.size();
		end
	end

endmodule

// ===== test/tb_window_rms_min_max.sv =====
// Testbench top for window_rms_min_max: drives samples, register writes and pops; gives the verdict.
`timescale 1ns / 1ps

module tb_window_rms_min_max;
	import wrm_pkg::*;

	localparam int   SB           = SAMPLE_BITS_DEF;
	localparam int   CB           = COUNT_BITS_DEF;
	localparam logic REG_UNUSED   = 1'b1;
	localparam int   CYCLE_LIMIT  = 400000;
	localparam int   DRAIN_CYCLES = 2 * SB + CB + SB + 8;
	localparam int   HOLD_CYCLES  = 600;

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;
	logic [SB-1:0]            sample;
	logic                     push;
	logic                     full;
	logic [SB-1:0]            rms_value;
	logic [SB-1:0]            min_value;
	logic [SB-1:0]            max_value;
	logic [CB-1:0]            samples_seen;
	logic                     empty;
	logic                     pop;

	int fail_count;
	int words_pending;
	bit steady;
	bit hold_req;

	window_rms_min_max dut (.*);

	window_rms_min_max_checker #(.SAMPLE_BITS(SB), .COUNT_BITS(CB)) stats_check (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.sample(sample), .push(push), .full(full),
		.rms_value(rms_value), .min_value(min_value), .max_value(max_value),
		.samples_seen(samples_seen), .empty(empty), .pop(pop),
		.fail_count(fail_count), .words_pending(words_pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_window_rms_min_max failed");
		$finish;
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && hold_left == 0) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= steady || $urandom_range(99) >= 13;
			end
		end
	end

	function automatic logic [SB-1:0] pick_sample();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return SB'($urandom_range(255));
			3: return ~SB'($urandom_range(255));
			default: return SB'($urandom());
		endcase
	endfunction

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic send_word(input logic [SB-1:0] value);
		while (!steady && $urandom_range(99) < 13) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		sample <= value;
		do
			@(posedge clk);
		while (full);
		@(negedge clk);
	endtask

	task automatic send_burst(input int words);
		for (int i = 0; i < words; i++)
			send_word(pick_sample());
		push <= 1'b0;
		@(negedge clk);
		while (words_pending != 0)
			@(negedge clk);
	endtask

	// write register idx, then read back window_len
	task automatic reg_write(input logic idx, input logic [CB-1:0] len);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_BITS'({idx, 2'b00});
		pwdata <= ($urandom() & ~32'(2 ** CB - 1)) | 32'(len);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= APB_ADDR_BITS'({REG_WINDOW_LEN, 2'b00});
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_phase(input logic [CB-1:0] len, input int words);
		reg_write(REG_WINDOW_LEN, len);
		send_burst(words);
	endtask

	initial begin
		logic [SB-1:0] opening[$];
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample = '0;
		push = 1'b0;
		steady = 1'b0;
		hold_req = 1'b0;
		// extremes, ties, new min, new max, neither
		opening = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE,
			16'h5555, 16'hAAAA, 16'h0100, 16'h0100, 16'h00FF, 16'h0200, 16'h0001,
			16'hFFFF, 16'h0000, 16'h1234, 16'hFEDC, 16'h0F0F, 16'hF0F0, 16'h8001};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (opening[i])
			send_word(opening[i]);
		send_burst(0);

		run_phase(12'd1, 8);
		run_phase(12'd0, 8);
		run_phase(12'd2, 40);
		run_phase(12'd3, 50);
		steady = 1'b1;
		run_phase(12'd7, 80);
		steady = 1'b0;
		hold_req = 1'b1;
		run_phase(12'd16, 100);
		run_phase(12'd4095, 60);
		// shrink below the running count: next word closes the window
		run_phase(12'd5, 40);
		reg_write(REG_UNUSED, 12'd1);
		send_burst(30);
		run_phase(12'd500, 200);
		for (int i = 0; i < 7; i++)
			run_phase(CB'($urandom_range(1, 40)), $urandom_range(30, 60));
		run_phase(12'd4095, 20);

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("tb_window_rms_min_max passed");
		else
			$display("tb_window_rms_min_max failed");
		$finish;
	end

endmodule
